// ===== sv/coapmp_pkg.sv =====
// ----------------------------------------------------------------------------
// coapmp_pkg
// Shared types and constants of the CoAP message parser.
// ----------------------------------------------------------------------------
package coapmp_pkg;

  // byte classification
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_TOKEN   = 3'd1;
  localparam logic [2:0] KIND_OPT_HDR = 3'd2;
  localparam logic [2:0] KIND_OPT_VAL = 3'd3;
  localparam logic [2:0] KIND_MARKER  = 3'd4;
  localparam logic [2:0] KIND_PAYLOAD = 3'd5;
  localparam logic [2:0] KIND_DISCARD = 3'd6;

  // datagram status
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // format constants
  localparam logic [7:0]  OPT_MARKER    = 8'hFF;
  localparam logic [1:0]  PROTO_VERSION = 2'd1;
  localparam logic [3:0]  MAX_TKL       = 4'd8;
  localparam logic [3:0]  NIB_EXT8      = 4'd13;
  localparam logic [3:0]  NIB_EXT16     = 4'd14;
  localparam logic [3:0]  NIB_RSVD      = 4'd15;
  localparam logic [16:0] EXT8_BASE     = 17'd13;
  localparam logic [16:0] EXT16_BASE    = 17'd269;

  // register map
  localparam logic [4:0] OPT_CAP_RST = 5'd8;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_out;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  msg_code;
    logic [15:0] message_id;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic        option_kept;
    logic [4:0]  kept_options;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== sv/coapmp_core.sv =====
// ----------------------------------------------------------------------------
// coapmp_core
// Datagram parse state and the per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module coapmp_core
  import coapmp_pkg::*;
#(
  parameter int MAX_OPTION_RECORDS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data,
  input  logic       last,
  input  logic [4:0] opt_cap,
  output result_t    res
);

  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_TOKEN   = 4'd1;
  localparam logic [3:0] PH_OPT     = 4'd2;
  localparam logic [3:0] PH_DEXT1   = 4'd3;
  localparam logic [3:0] PH_DEXT2H  = 4'd4;
  localparam logic [3:0] PH_DEXT2L  = 4'd5;
  localparam logic [3:0] PH_LEXT1   = 4'd6;
  localparam logic [3:0] PH_LEXT2H  = 4'd7;
  localparam logic [3:0] PH_LEXT2L  = 4'd8;
  localparam logic [3:0] PH_VALUE   = 4'd9;
  localparam logic [3:0] PH_PAYLOAD = 4'd10;
  localparam logic [3:0] PH_DISCARD = 4'd11;

  localparam logic [6:0] MaxRec = 7'(MAX_OPTION_RECORDS);

  logic [3:0]  phase, phase_next;
  logic [1:0]  hdr_cnt, hdr_cnt_next;
  logic [3:0]  token_left, token_left_next;
  logic [29:0] held_header, held_header_next;
  logic [15:0] prev_number, prev_number_next;
  logic [3:0]  len_nib, len_nib_next;
  logic [7:0]  ext_acc, ext_acc_next;
  logic [16:0] value_left, value_left_next;
  logic [4:0]  kept_count, kept_count_next;
  logic        error_seen, error_seen_next;
  logic [16:0] cur_length, cur_length_next;
  logic        cur_kept, cur_kept_next;

  logic [4:0]  limit;
  logic [2:0]  kind;

  // effective record limit: min(opt_cap, MAX_OPTION_RECORDS)
  assign limit = ({2'b00, opt_cap} > MaxRec) ? MaxRec[4:0] : opt_cap;

  always_comb begin
    logic        do_delta;
    logic        do_len;
    logic [16:0] delta_v;
    logic [16:0] len_v;
    logic [3:0]  nib;

    phase_next       = phase;
    hdr_cnt_next     = hdr_cnt;
    token_left_next  = token_left;
    held_header_next = held_header;
    prev_number_next = prev_number;
    len_nib_next     = len_nib;
    ext_acc_next     = ext_acc;
    value_left_next  = value_left;
    kept_count_next  = kept_count;
    error_seen_next  = error_seen;
    cur_length_next  = cur_length;
    cur_kept_next    = cur_kept;
    kind             = KIND_DISCARD;
    do_delta         = 1'b0;
    do_len           = 1'b0;
    delta_v          = '0;
    len_v            = '0;
    nib              = len_nib;

    case (phase)
      PH_HEADER: begin
        kind = KIND_HEADER;
        hdr_cnt_next = hdr_cnt + 2'd1;
        case (hdr_cnt)
          2'd0: begin
            held_header_next[29:28] = data[5:4];
            held_header_next[27:24] = data[3:0];
            if (data[7:6] != PROTO_VERSION || data[3:0] > MAX_TKL) begin
              error_seen_next = 1'b1;
              phase_next      = PH_DISCARD;
              hdr_cnt_next    = hdr_cnt;
            end
          end
          2'd1: held_header_next[23:16] = data;
          2'd2: held_header_next[15:8]  = data;
          default: begin
            held_header_next[7:0] = data;
            token_left_next = held_header[27:24];
            phase_next = (held_header[27:24] != 4'd0) ? PH_TOKEN : PH_OPT;
          end
        endcase
      end
      PH_TOKEN: begin
        kind = KIND_TOKEN;
        token_left_next = token_left - 4'd1;
        if (token_left_next == 4'd0) phase_next = PH_OPT;
      end
      PH_OPT: begin
        if (data == OPT_MARKER) begin
          kind       = KIND_MARKER;
          phase_next = PH_PAYLOAD;
        end else begin
          kind            = KIND_OPT_HDR;
          len_nib_next    = data[3:0];
          nib             = data[3:0];
          cur_length_next = '0;
          cur_kept_next   = 1'b0;
          if (data[7:4] == NIB_RSVD || data[3:0] == NIB_RSVD) begin
            error_seen_next = 1'b1;
            phase_next      = PH_DISCARD;
          end else if (data[7:4] == NIB_EXT8) begin
            phase_next = PH_DEXT1;
          end else if (data[7:4] == NIB_EXT16) begin
            phase_next = PH_DEXT2H;
          end else begin
            do_delta = 1'b1;
            delta_v  = {13'd0, data[7:4]};
          end
        end
      end
      PH_DEXT1: begin
        kind     = KIND_OPT_HDR;
        do_delta = 1'b1;
        delta_v  = EXT8_BASE + {9'd0, data};
      end
      PH_DEXT2H: begin
        kind         = KIND_OPT_HDR;
        ext_acc_next = data;
        phase_next   = PH_DEXT2L;
      end
      PH_DEXT2L: begin
        kind     = KIND_OPT_HDR;
        do_delta = 1'b1;
        delta_v  = EXT16_BASE + {1'b0, ext_acc, data};
      end
      PH_LEXT1: begin
        kind   = KIND_OPT_HDR;
        do_len = 1'b1;
        len_v  = EXT8_BASE + {9'd0, data};
      end
      PH_LEXT2H: begin
        kind         = KIND_OPT_HDR;
        ext_acc_next = data;
        phase_next   = PH_LEXT2L;
      end
      PH_LEXT2L: begin
        kind   = KIND_OPT_HDR;
        do_len = 1'b1;
        len_v  = EXT16_BASE + {1'b0, ext_acc, data};
      end
      PH_VALUE: begin
        kind = KIND_OPT_VAL;
        value_left_next = value_left - 17'd1;
        if (value_left_next == 17'd0) phase_next = PH_OPT;
      end
      PH_PAYLOAD: kind = KIND_PAYLOAD;
      default: begin
        kind       = KIND_DISCARD;
        phase_next = PH_DISCARD;
      end
    endcase

    // delta applied: option number wraps at 16 bits, then length nibble
    if (do_delta) begin
      prev_number_next = prev_number + delta_v[15:0];
      if (nib == NIB_EXT8) begin
        phase_next = PH_LEXT1;
      end else if (nib == NIB_EXT16) begin
        phase_next = PH_LEXT2H;
      end else begin
        do_len = 1'b1;
        len_v  = {13'd0, nib};
      end
    end

    // length known: count the record if room remains
    if (do_len) begin
      cur_length_next = len_v;
      cur_kept_next   = (kept_count < limit);
      if (kept_count < limit) kept_count_next = kept_count + 5'd1;
      value_left_next = len_v;
      phase_next      = (len_v != 17'd0) ? PH_VALUE : PH_OPT;
    end
  end

  always_comb begin
    res.byte_kind     = kind;
    res.byte_out      = data;
    res.msg_type      = held_header_next[29:28];
    res.token_length  = held_header_next[27:24];
    res.msg_code      = held_header_next[23:16];
    res.message_id    = held_header_next[15:0];
    res.option_number = prev_number_next;
    res.option_length = cur_length_next;
    res.option_kept   = cur_kept_next;
    res.kept_options  = kept_count_next;
    if (error_seen_next) begin
      res.status = ST_ERR;
    end else if (last) begin
      res.status = (phase_next == PH_OPT || phase_next == PH_PAYLOAD) ? ST_OK : ST_ERR;
    end else begin
      res.status = ST_BUSY;
    end
  end

  // a last byte returns the whole datagram state to its reset value
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase       <= PH_HEADER;
      hdr_cnt     <= '0;
      token_left  <= '0;
      held_header <= '0;
      prev_number <= '0;
      len_nib     <= '0;
      ext_acc     <= '0;
      value_left  <= '0;
      kept_count  <= '0;
      error_seen  <= 1'b0;
      cur_length  <= '0;
      cur_kept    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      hdr_cnt     <= hdr_cnt_next;
      token_left  <= token_left_next;
      held_header <= held_header_next;
      prev_number <= prev_number_next;
      len_nib     <= len_nib_next;
      ext_acc     <= ext_acc_next;
      value_left  <= value_left_next;
      kept_count  <= kept_count_next;
      error_seen  <= error_seen_next;
      cur_length  <= cur_length_next;
      cur_kept    <= cur_kept_next;
    end
  end

endmodule

// ===== sv/coap_message_parser_top.sv =====
// An accepted byte passes the input register, then the result register, before its result shows.
// Throughput: one byte per cycle; the only limit is downstream out_stall.
// The single-byte parse step sits between the input register and result register.
// Reset (rst, synchronous): parse state cleared, both stages empty,
// option cap register back to 8.
// ----------------------------------------------------------------------------
// coap_message_parser_top
// Streaming CoAP datagram parser: classifies each byte and reports header and
// option fields, with an APB register for the option record limit.
// ----------------------------------------------------------------------------
module coap_message_parser_top
  import coapmp_pkg::*;
#(
  parameter int MAX_OPTION_RECORDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_kind,
  output logic [7:0]  byte_out,
  output logic [1:0]  msg_type,
  output logic [3:0]  token_length,
  output logic [7:0]  msg_code,
  output logic [15:0] message_id,
  output logic [15:0] option_number,
  output logic [16:0] option_length,
  output logic        option_kept,
  output logic [4:0]  kept_options,
  output logic [1:0]  status,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration: option cap at byte address 0 (paddr[2] selects register)
  // --------------------------------------------------------------------------
  logic [4:0] opt_cap;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {27'd0, opt_cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      opt_cap <= OPT_CAP_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      opt_cap <= pwdata[4:0];
    end
  end

  // --------------------------------------------------------------------------
  // Input register stage
  // --------------------------------------------------------------------------
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       advance;   // input stage moves into the result register
  logic       in_take;

  // the result register frees up when empty or when its transaction completes
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Parse step: state advances exactly when the byte enters the result reg
  // --------------------------------------------------------------------------
  result_t step_res;
  result_t res_q;

  coapmp_core #(
    .MAX_OPTION_RECORDS(MAX_OPTION_RECORDS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .data   (s1_data),
    .last   (s1_last),
    .opt_cap(opt_cap),
    .res    (step_res)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign byte_kind     = res_q.byte_kind;
  assign byte_out      = res_q.byte_out;
  assign msg_type      = res_q.msg_type;
  assign token_length  = res_q.token_length;
  assign msg_code      = res_q.msg_code;
  assign message_id    = res_q.message_id;
  assign option_number = res_q.option_number;
  assign option_length = res_q.option_length;
  assign option_kept   = res_q.option_kept;
  assign kept_options  = res_q.kept_options;
  assign status        = res_q.status;

endmodule

// ===== sv/coapmp_checker.sv =====
// ----------------------------------------------------------------------------
// coapmp_checker
// Port-level checks on the CoAP parser's result channel.
// ----------------------------------------------------------------------------
module coapmp_checker
  import coapmp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] byte_kind,
  input logic       option_kept,
  input logic [4:0] kept_options,
  input logic [1:0] status
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_kind) && $stable(status))
    else $error("stalled result changed");

  // a discarded byte only follows an error
  a_discard_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == KIND_DISCARD |-> status == ST_ERR)
    else $error("discarded byte without error status");

  // a good datagram never ends on a discarded byte
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> byte_kind != KIND_DISCARD)
    else $error("ok status on discarded byte");

  // a kept option has been counted
  a_kept_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && option_kept |-> kept_options != 5'd0)
    else $error("kept option with zero count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind coap_message_parser_top coapmp_checker u_coapmp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .byte_kind   (byte_kind),
  .option_kept (option_kept),
  .kept_options(kept_options),
  .status      (status)
);
